[design/rtp_pkg.sv]
package rtp_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned RadixW  = 5;
  localparam int unsigned DigitW  = 5;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 8;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgRadix  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgSigned = 4'd1;

  localparam logic [RadixW-1:0] RadixReset = 5'd10;
  localparam logic [RadixW-1:0] RadixDec   = 5'd10;
  localparam logic [RadixW-1:0] RadixMin   = 5'd2;
  localparam logic [RadixW-1:0] RadixMax   = 5'd16;

  localparam logic [ValueW-1:0] PosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValueW-1:0] NegLimit = 64'h8000_0000_0000_0000;
  localparam logic [ValueW-1:0] UnsLimit = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [DigitW-1:0] NoDigit = 5'd31;

  localparam logic [ByteW-1:0] ChMinus = 8'h2D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChLf    = 8'h0A;
  localparam logic [ByteW-1:0] ChCr    = 8'h0D;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpF   = 8'h46;
  localparam logic [ByteW-1:0] ChLoA   = 8'h61;
  localparam logic [ByteW-1:0] ChLoF   = 8'h66;

  typedef enum logic [StatusW-1:0] {
    StOk       = 3'd0,
    StRadix    = 3'd1,
    StNoLead   = 3'd2,
    StOverflow = 3'd3,
    StEarly    = 3'd4
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             source_end;
  } in_item_t;

  typedef struct packed {
    logic [ValueW-1:0]  number_value;
    logic [StatusW-1:0] parse_status;
    logic [ByteW-1:0]   stop_byte;
    logic               stop_byte_valid;
  } out_item_t;

  typedef struct packed {
    logic [RadixW-1:0] number_radix;
    logic              signed_mode;
  } cfg_t;

  // Handshake between the input register and the parser core.
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

  function automatic logic [DigitW-1:0] digit_of(input logic [ByteW-1:0] c);
    logic [DigitW-1:0] d;
    d = NoDigit;
    if (c >= ChZero && c <= ChNine) begin
      d = DigitW'(c - ChZero);
    end else if (c >= ChUpA && c <= ChUpF) begin
      d = DigitW'(c - ChUpA + 8'd10);
    end else if (c >= ChLoA && c <= ChLoF) begin
      d = DigitW'(c - ChLoA + 8'd10);
    end
    return d;
  endfunction

endpackage

[design/radix_integer_text_parser_top.sv]
// Streaming text-to-integer parser. Bytes enter on the input channel, one
// request per cycle while not stalled; each number is delivered as one
// result carrying the value, a status code, and the byte that ended it. An
// accepted byte sits in an input register, then the parser core does the
// whole step (digit decode, one multiply-add by the radix, the overflow
// compare) combinationally and loads the result register, so the block
// sustains one byte per cycle while the output is not stalled.
// The only stall comes from the output side: a byte that produces a result
// waits while the result register is full and stalled. Configuration
// writes (index 0 radix, index 1 signed mode) are always ready and should
// be made only while no bytes are in flight.
module radix_integer_text_parser_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rtp_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output rtp_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rtp_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rtp_pkg::CfgDatW-1:0]         cfg_data_i
);

  rtp_pkg::cfg_t       cfg_q;
  rtp_pkg::stage_ctl_t ctl;
  rtp_pkg::in_item_t   item;
  rtp_pkg::out_item_t  res;
  rtp_pkg::out_item_t  out_q;
  logic                out_valid_q;
  logic                advance;
  logic                res_valid;
  logic                out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.number_radix <= rtp_pkg::RadixReset;
      cfg_q.signed_mode  <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rtp_pkg::CfgRadix) begin
        cfg_q.number_radix <= cfg_data_i[rtp_pkg::RadixW-1:0];
      end else if (cfg_index_i == rtp_pkg::CfgSigned) begin
        cfg_q.signed_mode <= cfg_data_i[0];
      end
    end
  end

  rtp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .ctl_o      (ctl),
    .advance_i  (advance),
    .item_o     (item)
  );

  rtp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/rtp_in_stage.sv]
module rtp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rtp_pkg::in_item_t   in_data_i,
  output rtp_pkg::stage_ctl_t ctl_o,
  input  logic                advance_i,
  output rtp_pkg::in_item_t   item_o
);

  logic              valid_q;
  rtp_pkg::in_item_t data_q;
  logic              accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign ctl_o.valid = valid_q;
  assign item_o      = data_q;

endmodule

[design/rtp_core.sv]
module rtp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtp_pkg::stage_ctl_t ctl_i,
  input  rtp_pkg::in_item_t   item_i,
  input  rtp_pkg::cfg_t       cfg_i,
  input  logic                out_free_i,
  output logic                advance_o,
  output logic                res_valid_o,
  output rtp_pkg::out_item_t  res_o
);

  localparam logic [1:0] PhSkip   = 2'd0;
  localparam logic [1:0] PhSign   = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;

  localparam int unsigned ProdW = rtp_pkg::ValueW + rtp_pkg::RadixW;

  logic [1:0]                  phase_q, phase_d;
  logic [rtp_pkg::ValueW-1:0]  acc_q, acc_d;
  logic                        minus_q, minus_d;
  logic                        err_q, err_d;

  logic [rtp_pkg::ByteW-1:0]   b;
  logic                        src_end;
  logic                        sgn;
  logic [rtp_pkg::RadixW-1:0]  base;
  logic                        base_ok;
  logic                        ws;
  logic [rtp_pkg::DigitW-1:0]  d;
  logic                        is_digit;
  logic                        is_minus;
  logic [rtp_pkg::ValueW-1:0]  limit;
  logic [ProdW-1:0]            prod;
  logic [ProdW:0]              sum;
  logic                        ovf;
  logic [rtp_pkg::ValueW-1:0]  acc_new;
  logic                        neg;

  assign b        = item_i.text_byte;
  assign src_end  = item_i.source_end;
  assign sgn      = cfg_i.signed_mode;
  assign base     = sgn ? rtp_pkg::RadixDec : cfg_i.number_radix;
  assign base_ok  = sgn || (cfg_i.number_radix >= rtp_pkg::RadixMin &&
                            cfg_i.number_radix <= rtp_pkg::RadixMax);
  assign ws       = b == rtp_pkg::ChSpace || b == rtp_pkg::ChLf ||
                    b == rtp_pkg::ChCr || b == rtp_pkg::ChTab;
  assign d        = rtp_pkg::digit_of(b);
  assign is_digit = base_ok && (d < base);
  assign is_minus = sgn && (b == rtp_pkg::ChMinus);

  // Digit acceptance: acc * base + d must stay within the limit.
  assign limit = !sgn ? rtp_pkg::UnsLimit :
                 (minus_q ? rtp_pkg::NegLimit : rtp_pkg::PosLimit);
  assign prod  = {{rtp_pkg::RadixW{1'b0}}, acc_q} *
                 {{rtp_pkg::ValueW{1'b0}}, base};
  assign sum   = {1'b0, prod} + (ProdW + 1)'(d);
  assign ovf   = sum > (ProdW + 1)'(limit);
  assign neg   = sgn && minus_q;

  always_comb begin
    logic digit_taken;
    digit_taken = 1'b0;
    phase_d     = phase_q;
    acc_d       = acc_q;
    minus_d     = minus_q;
    err_d       = err_q;
    res_valid_o = 1'b0;
    acc_new     = acc_q;
    res_o       = '0;
    res_o.parse_status = rtp_pkg::StOk;

    if (err_q) begin
      if (src_end) begin
        phase_d = PhSkip;
        acc_d   = '0;
        minus_d = 1'b0;
        err_d   = 1'b0;
      end
    end else begin
      unique case (phase_q)
        PhSkip: begin
          if (ws) begin
            if (src_end) begin
              res_valid_o        = 1'b1;
              res_o.parse_status = base_ok ? rtp_pkg::StEarly : rtp_pkg::StRadix;
            end
          end else if (!base_ok) begin
            res_valid_o           = 1'b1;
            res_o.parse_status    = rtp_pkg::StRadix;
            res_o.stop_byte       = b;
            res_o.stop_byte_valid = 1'b1;
          end else if (is_minus) begin
            minus_d = 1'b1;
            phase_d = PhSign;
            if (src_end) begin
              res_valid_o        = 1'b1;
              res_o.parse_status = rtp_pkg::StEarly;
            end
          end else if (!is_digit) begin
            res_valid_o           = 1'b1;
            res_o.parse_status    = rtp_pkg::StNoLead;
            res_o.stop_byte       = b;
            res_o.stop_byte_valid = 1'b1;
          end else begin
            acc_new     = rtp_pkg::ValueW'(d);
            digit_taken = 1'b1;
          end
        end
        PhSign: begin
          if (!base_ok || !is_digit) begin
            res_valid_o           = 1'b1;
            res_o.parse_status    = !base_ok ? rtp_pkg::StRadix : rtp_pkg::StNoLead;
            res_o.stop_byte       = b;
            res_o.stop_byte_valid = 1'b1;
          end else begin
            acc_new     = rtp_pkg::ValueW'(d);
            digit_taken = 1'b1;
          end
        end
        default: begin
          if (!base_ok) begin
            res_valid_o           = 1'b1;
            res_o.parse_status    = rtp_pkg::StRadix;
            res_o.stop_byte       = b;
            res_o.stop_byte_valid = 1'b1;
          end else if (is_digit) begin
            if (ovf) begin
              res_valid_o        = 1'b1;
              res_o.parse_status = rtp_pkg::StOverflow;
            end else begin
              acc_new     = sum[rtp_pkg::ValueW-1:0];
              digit_taken = 1'b1;
            end
          end else begin
            // Delimiter: deliver the number; a minus may open the next one.
            res_valid_o           = 1'b1;
            res_o.number_value    = neg ? (rtp_pkg::ValueW'(0) - acc_q) : acc_q;
            res_o.stop_byte       = b;
            res_o.stop_byte_valid = 1'b1;
            phase_d = PhSkip;
            acc_d   = '0;
            minus_d = 1'b0;
            if (!src_end && is_minus) begin
              minus_d = 1'b1;
              phase_d = PhSign;
            end
          end
        end
      endcase

      if (res_valid_o && res_o.parse_status != rtp_pkg::StOk) begin
        // Any error clears the number and holds off until the source ends.
        phase_d = PhSkip;
        acc_d   = '0;
        minus_d = 1'b0;
        err_d   = !src_end;
      end else if (digit_taken) begin
        if (src_end) begin
          res_valid_o        = 1'b1;
          res_o.number_value = neg ? (rtp_pkg::ValueW'(0) - acc_new) : acc_new;
          phase_d = PhSkip;
          acc_d   = '0;
          minus_d = 1'b0;
        end else begin
          acc_d   = acc_new;
          phase_d = PhDigits;
        end
      end
    end
  end

  assign advance_o = ctl_i.valid && (!res_valid_o || out_free_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      acc_q   <= '0;
      minus_q <= 1'b0;
      err_q   <= 1'b0;
    end else if (advance_o) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      err_q   <= err_d;
    end
  end

endmodule
